// ===== rtl/sla_pkg.sv =====
package sla_pkg;

    localparam int MAX_DIM   = 32;
    localparam int FRAC_BITS = 16;
    localparam int DW        = 32;
    localparam int CW        = 6;
    localparam int TS_W      = 16;
    localparam int GRID_D    = MAX_DIM + 2;
    localparam int GRID_N    = GRID_D * GRID_D * GRID_D;
    localparam int AW        = $clog2(GRID_N);
    localparam int BW        = CW + FRAC_BITS;
    localparam int DTN_W     = TS_W + CW;
    localparam int MA        = DW + 1;
    localparam int MB        = (DTN_W + 1 > FRAC_BITS + 2) ? DTN_W + 1 : FRAC_BITS + 2;
    localparam int PW        = MA + MB;
    localparam int TW        = PW - FRAC_BITS + 1;

    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_RUN  = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    localparam logic [1:0] COMP_SCALAR = 2'd0;
    localparam logic [1:0] COMP_X      = 2'd1;
    localparam logic [1:0] COMP_Y      = 2'd2;
    localparam logic [1:0] COMP_Z      = 2'd3;

    // configuration register indexes
    localparam logic [2:0] REG_SIZE_X    = 3'd0;
    localparam logic [2:0] REG_SIZE_Y    = 3'd1;
    localparam logic [2:0] REG_SIZE_Z    = 3'd2;
    localparam logic [2:0] REG_TIME_STEP = 3'd3;
    localparam logic [2:0] REG_COMPONENT = 3'd4;

    // write side of the cell store
    typedef struct packed {
        logic          src_we;
        logic          vel_we;
        logic          tgt_we;
        logic          sol_we;
        logic [AW-1:0] waddr;
        logic [DW-1:0] src;
        logic [DW-1:0] vx;
        logic [DW-1:0] vy;
        logic [DW-1:0] vz;
        logic [DW-1:0] tgt;
        logic          sol;
    } sla_wr_t;

    // registered read data of the cell store
    typedef struct packed {
        logic [DW-1:0] src;
        logic [DW-1:0] vx;
        logic [DW-1:0] vy;
        logic [DW-1:0] vz;
        logic [DW-1:0] tgt;
        logic          sol;
    } sla_rd_t;

    function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] x,
                                                input logic [CW-1:0] y,
                                                input logic [CW-1:0] z);
        int a;
        a = (int'(z) * GRID_D + int'(y)) * GRID_D + int'(x);
        return AW'(a);
    endfunction

    function automatic logic [CW-1:0] eff_size(input logic [CW-1:0] v);
        logic [CW-1:0] r;
        if (v == '0)
            r = CW'(1);
        else if (v > CW'(MAX_DIM))
            r = CW'(MAX_DIM);
        else
            r = v;
        return r;
    endfunction

    function automatic logic [DW-1:0] neg_sat(input logic [DW-1:0] a);
        logic [DW-1:0] r;
        if (a == {1'b1, {(DW-1){1'b0}}})
            r = {1'b0, {(DW-1){1'b1}}};
        else
            r = -a;
        return r;
    endfunction

endpackage

// ===== rtl/sla_cellmem.sv =====
module sla_cellmem (
    input  logic            aclk,
    input  sla_pkg::sla_wr_t wr,
    input  logic [sla_pkg::AW-1:0] raddr,
    output sla_pkg::sla_rd_t rd
);

    logic [sla_pkg::DW-1:0] src_mem [sla_pkg::GRID_N];
    logic [sla_pkg::DW-1:0] vx_mem  [sla_pkg::GRID_N];
    logic [sla_pkg::DW-1:0] vy_mem  [sla_pkg::GRID_N];
    logic [sla_pkg::DW-1:0] vz_mem  [sla_pkg::GRID_N];
    logic [sla_pkg::DW-1:0] tgt_mem [sla_pkg::GRID_N];
    logic                   sol_mem [sla_pkg::GRID_N];
    sla_pkg::sla_rd_t       rd_reg;

    always_ff @(posedge aclk) begin
        if (wr.src_we) begin
            src_mem[wr.waddr] <= wr.src;
        end
        if (wr.vel_we) begin
            vx_mem[wr.waddr] <= wr.vx;
            vy_mem[wr.waddr] <= wr.vy;
            vz_mem[wr.waddr] <= wr.vz;
        end
        if (wr.tgt_we) begin
            tgt_mem[wr.waddr] <= wr.tgt;
        end
        if (wr.sol_we) begin
            sol_mem[wr.waddr] <= wr.sol;
        end
    end

    always_ff @(posedge aclk) begin
        rd_reg.src <= src_mem[raddr];
        rd_reg.vx  <= vx_mem[raddr];
        rd_reg.vy  <= vy_mem[raddr];
        rd_reg.vz  <= vz_mem[raddr];
        rd_reg.tgt <= tgt_mem[raddr];
        rd_reg.sol <= sol_mem[raddr];
    end

    assign rd = rd_reg;

endmodule

// ===== rtl/sla_mul.sv =====
module sla_mul (
    input  logic                           aclk,
    input  logic signed [sla_pkg::MA-1:0]  a,
    input  logic signed [sla_pkg::MB-1:0]  b,
    output logic signed [sla_pkg::PW-1:0]  prod
);

    logic signed [sla_pkg::PW-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;

endmodule

// ===== rtl/grid_semi_lagrangian_advect_unit.sv =====
// channel   dir  handshake            payload
// s_        in   s_tvalid / s_tready  s_tdata: cell coords, cell values, solid; s_tuser: opcode
// m_        out  m_tvalid / m_tready  m_tdata: read_value; m_tuser: done_res
// cfg_      in   cfg_valid / cfg_ready cfg_addr: register index; cfg_data: value
//
// load and unknown-opcode transactions are answered from idle, a read from its own read state
// a run walks the grid under one sequencer around a shared multiplier: it advects
//   each fluid cell, zeroes each solid cell, applies the face rules to each face cell pair
//   and then, for velocity components only, runs the no-slip pass over the interior cells
// after reset the solid map is cleared one cell a cycle, all 39304 cells, with s_tready low
// a two-entry result buffer keeps s_tready off m_tready; s_tready is low while a
// run or read is in progress or both result entries are full
module grid_semi_lagrangian_advect_unit (
    input  logic         aclk,
    input  logic         aresetn,
    // opcode and cell data
    input  logic         s_tvalid,
    output logic         s_tready,
    // cell_x[5:0] cell_y[11:6] cell_z[17:12] source_value[49:18] vel_x[81:50]
    // vel_y[113:82] vel_z[145:114] target_value[177:146] solid[178]
    input  logic [183:0] s_tdata,
    // opcode[1:0]
    input  logic [1:0]   s_tuser,
    // results
    output logic         m_tvalid,
    input  logic         m_tready,
    // read_value[31:0]
    output logic [31:0]  m_tdata,
    // done_res[0]
    output logic [0:0]   m_tuser,
    // register writes
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_addr,
    input  logic [15:0]  cfg_data
);

    localparam int F  = sla_pkg::FRAC_BITS;
    localparam int CW = sla_pkg::CW;
    localparam int DW = sla_pkg::DW;

    // neighbor codes of the no-slip pass
    localparam logic [2:0] NB_SELF = 3'd0;
    localparam logic [2:0] NB_XP   = 3'd1;
    localparam logic [2:0] NB_XM   = 3'd2;
    localparam logic [2:0] NB_YP   = 3'd3;
    localparam logic [2:0] NB_YM   = 3'd4;
    localparam logic [2:0] NB_ZP   = 3'd5;
    localparam logic [2:0] NB_ZM   = 3'd6;

    localparam logic [4:0] S_CLR   = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_RD    = 5'd2;
    localparam logic [4:0] S_DTN   = 5'd3;
    localparam logic [4:0] S_DTN_W = 5'd4;
    localparam logic [4:0] S_C_RD  = 5'd5;
    localparam logic [4:0] S_C_CHK = 5'd6;
    localparam logic [4:0] S_T_MUL = 5'd7;
    localparam logic [4:0] S_T_SUB = 5'd8;
    localparam logic [4:0] S_K_RD  = 5'd9;
    localparam logic [4:0] S_K_CAP = 5'd10;
    localparam logic [4:0] S_B_M1  = 5'd11;
    localparam logic [4:0] S_B_M2  = 5'd12;
    localparam logic [4:0] S_B_ADD = 5'd13;
    localparam logic [4:0] S_F_RD  = 5'd14;
    localparam logic [4:0] S_F_WR  = 5'd15;
    localparam logic [4:0] S_N_RD  = 5'd16;
    localparam logic [4:0] S_N_CHK = 5'd17;
    localparam logic [4:0] S_DONE  = 5'd18;

    localparam logic [F-1:0] HALF_F = {1'b1, {(F-1){1'b0}}};

    // input fields
    logic [1:0]    in_op;
    logic [CW-1:0] in_x, in_y, in_z;
    logic [DW-1:0] in_src, in_vx, in_vy, in_vz, in_tgt;
    logic          in_sol, in_inside, s_acc;

    assign in_op  = s_tuser;
    assign in_x   = s_tdata[5:0];
    assign in_y   = s_tdata[11:6];
    assign in_z   = s_tdata[17:12];
    assign in_src = s_tdata[49:18];
    assign in_vx  = s_tdata[81:50];
    assign in_vy  = s_tdata[113:82];
    assign in_vz  = s_tdata[145:114];
    assign in_tgt = s_tdata[177:146];
    assign in_sol = s_tdata[178];
    assign in_inside = (in_x < CW'(sla_pkg::GRID_D)) && (in_y < CW'(sla_pkg::GRID_D))
                    && (in_z < CW'(sla_pkg::GRID_D));

    // registers
    logic [4:0]    state_reg, state_next;
    logic [sla_pkg::AW-1:0] clr_reg, clr_next;
    logic [CW-1:0] size_x_reg, size_y_reg, size_z_reg;
    logic [15:0]   dt_reg;
    logic [1:0]    comp_reg;
    logic          m_valid_reg, m_valid_next;
    logic [DW-1:0] m_data_reg, m_data_next;
    logic          m_done_reg, m_done_next;
    logic          sk_valid_reg, sk_valid_next;
    logic [DW-1:0] sk_data_reg, sk_data_next;
    logic          sk_done_reg, sk_done_next;
    logic          rd_in_reg, rd_in_next;
    logic [1:0]    ax_reg, ax_next;
    logic [CW-1:0] x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic [2:0]    k_reg, k_next;
    logic [sla_pkg::DTN_W-1:0] dtn_reg [3];
    logic [sla_pkg::DTN_W-1:0] dtn_next [3];
    logic [DW-1:0] vel_reg [3];
    logic [DW-1:0] vel_next [3];
    logic [CW-1:0] pos_reg [3];
    logic [CW-1:0] pos_next [3];
    logic [F-1:0]  frac_reg [3];
    logic [F-1:0]  frac_next [3];
    logic [DW-1:0] q_reg [8];
    logic [DW-1:0] q_next [8];
    logic signed [sla_pkg::PW-1:0] acc_reg, acc_next;
    logic [1:0]    fa_reg, fa_next;
    logic [CW-1:0] fu_reg, fu_next, fv_reg, fv_next;
    logic          side_reg, side_next;

    // result produced this cycle
    logic          res_push;
    logic [DW-1:0] res_data;
    logic          res_done;

    // effective sizes
    logic [CW-1:0] w_eff, h_eff, d_eff;
    assign w_eff = sla_pkg::eff_size(size_x_reg);
    assign h_eff = sla_pkg::eff_size(size_y_reg);
    assign d_eff = sla_pkg::eff_size(size_z_reg);

    // cell store and shared multiplier
    sla_pkg::sla_wr_t wr;
    sla_pkg::sla_rd_t rd;
    logic [sla_pkg::AW-1:0] raddr;
    logic signed [sla_pkg::MA-1:0] mul_a;
    logic signed [sla_pkg::MB-1:0] mul_b;
    logic signed [sla_pkg::PW-1:0] prod;

    sla_cellmem u_mem (
        .aclk  (aclk),
        .wr    (wr),
        .raddr (raddr),
        .rd    (rd)
    );

    sla_mul u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // per-axis selections
    logic [CW-1:0] i_ax, n_ax;
    always_comb begin
        case (ax_reg)
            2'd0: begin
                i_ax = x_reg;
                n_ax = w_eff;
            end
            2'd1: begin
                i_ax = y_reg;
                n_ax = h_eff;
            end
            default: begin
                i_ax = z_reg;
                n_ax = d_eff;
            end
        endcase
    end

    // trace back, clamp to [0.5, n + 0.5]
    logic signed [sla_pkg::PW-1:0] psh;
    logic signed [sla_pkg::TW-1:0] tsub, tlo, thi, tcl;
    always_comb begin
        psh  = prod >>> F;
        tsub = $signed({{(sla_pkg::TW-sla_pkg::BW){1'b0}}, i_ax, {F{1'b0}}})
             - $signed(psh[sla_pkg::TW-1:0]);
        tlo  = $signed({{(sla_pkg::TW-F){1'b0}}, HALF_F});
        thi  = $signed({{(sla_pkg::TW-sla_pkg::BW){1'b0}}, n_ax, HALF_F});
        if (tsub < tlo)
            tcl = tlo;
        else if (tsub > thi)
            tcl = thi;
        else
            tcl = tsub;
    end

    // blend level picks the fraction: x for the first four, y for two, z last
    logic [F-1:0] s_cur;
    logic [F:0]   one_minus_s;
    always_comb begin
        if (k_reg < 3'd4)
            s_cur = frac_reg[0];
        else if (k_reg < 3'd6)
            s_cur = frac_reg[1];
        else
            s_cur = frac_reg[2];
        one_minus_s = {1'b1, {F{1'b0}}} - {1'b0, s_cur};
    end

    logic signed [sla_pkg::PW-1:0] bsum;
    logic [DW-1:0] blend_r;
    always_comb begin
        bsum    = (acc_reg + prod) >>> F;
        blend_r = bsum[DW-1:0];
    end

    // interior walk
    logic last_cell;
    logic [CW-1:0] x_adv, y_adv, z_adv;
    always_comb begin
        last_cell = (x_reg == w_eff) && (y_reg == h_eff) && (z_reg == d_eff);
        x_adv = x_reg + CW'(1);
        y_adv = y_reg;
        z_adv = z_reg;
        if (x_reg == w_eff) begin
            x_adv = CW'(1);
            if (y_reg == h_eff) begin
                y_adv = CW'(1);
                z_adv = z_reg + CW'(1);
            end else begin
                y_adv = y_reg + CW'(1);
            end
        end
    end

    // face coordinates
    logic [CW-1:0] fn, fumax, fvmax, f_rd, f_wr;
    logic [sla_pkg::AW-1:0] f_rd_addr, f_wr_addr;
    logic f_neg;
    always_comb begin
        case (fa_reg)
            2'd0: begin
                fn    = w_eff;
                fumax = h_eff;
                fvmax = d_eff;
                f_neg = !side_reg && (comp_reg == sla_pkg::COMP_X);
            end
            2'd1: begin
                fn    = h_eff;
                fumax = w_eff;
                fvmax = d_eff;
                f_neg = (comp_reg == sla_pkg::COMP_Y);
            end
            default: begin
                fn    = d_eff;
                fumax = w_eff;
                fvmax = h_eff;
                f_neg = (comp_reg == sla_pkg::COMP_Z);
            end
        endcase
        f_rd = side_reg ? fn : CW'(1);
        f_wr = side_reg ? fn + CW'(1) : CW'(0);
        case (fa_reg)
            2'd0: begin
                f_rd_addr = sla_pkg::cell_addr(f_rd, fu_reg, fv_reg);
                f_wr_addr = sla_pkg::cell_addr(f_wr, fu_reg, fv_reg);
            end
            2'd1: begin
                f_rd_addr = sla_pkg::cell_addr(fu_reg, f_rd, fv_reg);
                f_wr_addr = sla_pkg::cell_addr(fu_reg, f_wr, fv_reg);
            end
            default: begin
                f_rd_addr = sla_pkg::cell_addr(fu_reg, fv_reg, f_rd);
                f_wr_addr = sla_pkg::cell_addr(fu_reg, fv_reg, f_wr);
            end
        endcase
    end

    // neighbor address and whether it lies inside the configured interior
    logic [sla_pkg::AW-1:0] nb_addr;
    logic nb_ok;
    always_comb begin
        case (k_reg)
            NB_SELF: begin
                nb_addr = sla_pkg::cell_addr(x_reg, y_reg, z_reg);
                nb_ok   = 1'b1;
            end
            NB_XP: begin
                nb_addr = sla_pkg::cell_addr(x_reg + CW'(1), y_reg, z_reg);
                nb_ok   = x_reg < w_eff;
            end
            NB_XM: begin
                nb_addr = sla_pkg::cell_addr(x_reg - CW'(1), y_reg, z_reg);
                nb_ok   = x_reg > CW'(1);
            end
            NB_YP: begin
                nb_addr = sla_pkg::cell_addr(x_reg, y_reg + CW'(1), z_reg);
                nb_ok   = y_reg < h_eff;
            end
            NB_YM: begin
                nb_addr = sla_pkg::cell_addr(x_reg, y_reg - CW'(1), z_reg);
                nb_ok   = y_reg > CW'(1);
            end
            NB_ZP: begin
                nb_addr = sla_pkg::cell_addr(x_reg, y_reg, z_reg + CW'(1));
                nb_ok   = z_reg < d_eff;
            end
            NB_ZM: begin
                nb_addr = sla_pkg::cell_addr(x_reg, y_reg, z_reg - CW'(1));
                nb_ok   = z_reg > CW'(1);
            end
            default: begin
                nb_addr = sla_pkg::cell_addr(x_reg, y_reg, z_reg);
                nb_ok   = 1'b0;
            end
        endcase
    end

    logic [sla_pkg::AW-1:0] cur_addr, corner_addr;
    assign cur_addr    = sla_pkg::cell_addr(x_reg, y_reg, z_reg);
    assign corner_addr = sla_pkg::cell_addr(pos_reg[0] + CW'(k_reg[0]),
                                            pos_reg[1] + CW'(k_reg[1]),
                                            pos_reg[2] + CW'(k_reg[2]));

    // one item in flight at most, so a free second entry always has room
    assign s_tready  = (state_reg == S_IDLE) && !sk_valid_reg;
    assign s_acc     = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // sequencer
    always_comb begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        m_done_next   = m_done_reg;
        sk_valid_next = sk_valid_reg;
        sk_data_next  = sk_data_reg;
        sk_done_next  = sk_done_reg;
        res_push      = 1'b0;
        res_data      = '0;
        res_done      = 1'b0;
        rd_in_next    = rd_in_reg;
        ax_next       = ax_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        z_next        = z_reg;
        k_next        = k_reg;
        dtn_next      = dtn_reg;
        vel_next      = vel_reg;
        pos_next      = pos_reg;
        frac_next     = frac_reg;
        q_next        = q_reg;
        acc_next      = acc_reg;
        fa_next       = fa_reg;
        fu_next       = fu_reg;
        fv_next       = fv_reg;
        side_next     = side_reg;
        wr            = '0;
        raddr         = cur_addr;
        mul_a         = '0;
        mul_b         = '0;

        case (state_reg)
            S_CLR: begin
                wr.sol_we = 1'b1;
                wr.waddr  = clr_reg;
                wr.sol    = 1'b0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == sla_pkg::AW'(sla_pkg::GRID_N - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                raddr = sla_pkg::cell_addr(in_x, in_y, in_z);
                if (s_acc) begin
                    case (in_op)
                        sla_pkg::OP_RUN: begin
                            ax_next    = 2'd0;
                            state_next = S_DTN;
                        end
                        sla_pkg::OP_READ: begin
                            rd_in_next = in_inside;
                            state_next = S_RD;
                        end
                        default: begin
                            if (in_op == sla_pkg::OP_LOAD && in_inside) begin
                                wr.src_we = 1'b1;
                                wr.vel_we = 1'b1;
                                wr.tgt_we = 1'b1;
                                wr.sol_we = 1'b1;
                            end
                            wr.waddr = raddr;
                            wr.src   = in_src;
                            wr.vx    = in_vx;
                            wr.vy    = in_vy;
                            wr.vz    = in_vz;
                            wr.tgt   = in_tgt;
                            wr.sol   = in_sol;
                            res_push = 1'b1;
                        end
                    endcase
                end
            end
            S_RD: begin
                res_push   = 1'b1;
                res_data   = rd_in_reg ? rd.tgt : '0;
                state_next = S_IDLE;
            end
            // time step times size, once per axis
            S_DTN: begin
                mul_a      = $signed({{(sla_pkg::MA-16){1'b0}}, dt_reg});
                mul_b      = $signed({{(sla_pkg::MB-CW){1'b0}}, n_ax});
                state_next = S_DTN_W;
            end
            S_DTN_W: begin
                dtn_next[ax_reg] = prod[sla_pkg::DTN_W-1:0];
                if (ax_reg == 2'd2) begin
                    x_next     = CW'(1);
                    y_next     = CW'(1);
                    z_next     = CW'(1);
                    state_next = S_C_RD;
                end else begin
                    ax_next    = ax_reg + 2'd1;
                    state_next = S_DTN;
                end
            end
            S_C_RD: begin
                raddr      = cur_addr;
                state_next = S_C_CHK;
            end
            S_C_CHK: begin
                ax_next     = 2'd0;
                vel_next[0] = (comp_reg == sla_pkg::COMP_X) ? rd.src : rd.vx;
                vel_next[1] = (comp_reg == sla_pkg::COMP_Y) ? rd.src : rd.vy;
                vel_next[2] = (comp_reg == sla_pkg::COMP_Z) ? rd.src : rd.vz;
                if (rd.sol) begin
                    // obstacle cells are zero
                    wr.tgt_we = 1'b1;
                    wr.waddr  = cur_addr;
                    wr.tgt    = '0;
                    x_next    = x_adv;
                    y_next    = y_adv;
                    z_next    = z_adv;
                    if (last_cell) begin
                        fa_next    = 2'd0;
                        fu_next    = CW'(1);
                        fv_next    = CW'(1);
                        side_next  = 1'b0;
                        state_next = S_F_RD;
                    end else begin
                        state_next = S_C_RD;
                    end
                end else begin
                    state_next = S_T_MUL;
                end
            end
            S_T_MUL: begin
                mul_a      = $signed({vel_reg[ax_reg][DW-1], vel_reg[ax_reg]});
                mul_b      = $signed({{(sla_pkg::MB-sla_pkg::DTN_W){1'b0}}, dtn_reg[ax_reg]});
                state_next = S_T_SUB;
            end
            S_T_SUB: begin
                pos_next[ax_reg]  = tcl[sla_pkg::BW-1:F];
                frac_next[ax_reg] = tcl[F-1:0];
                if (ax_reg == 2'd2) begin
                    k_next     = 3'd0;
                    state_next = S_K_RD;
                end else begin
                    ax_next    = ax_reg + 2'd1;
                    state_next = S_T_MUL;
                end
            end
            S_K_RD: begin
                raddr      = corner_addr;
                state_next = S_K_CAP;
            end
            S_K_CAP: begin
                q_next[k_reg] = rd.src;
                if (k_reg == 3'd7) begin
                    k_next     = 3'd0;
                    state_next = S_B_M1;
                end else begin
                    k_next     = k_reg + 3'd1;
                    state_next = S_K_RD;
                end
            end
            // blend the two oldest queue entries, append the result
            S_B_M1: begin
                mul_a      = $signed({q_reg[0][DW-1], q_reg[0]});
                mul_b      = $signed({{(sla_pkg::MB-F-1){1'b0}}, one_minus_s});
                state_next = S_B_M2;
            end
            S_B_M2: begin
                acc_next   = prod;
                mul_a      = $signed({q_reg[1][DW-1], q_reg[1]});
                mul_b      = $signed({{(sla_pkg::MB-F){1'b0}}, s_cur});
                state_next = S_B_ADD;
            end
            S_B_ADD: begin
                for (int i = 0; i < 6; i++) begin
                    q_next[i] = q_reg[i+2];
                end
                q_next[3'd6 - k_reg] = blend_r;
                if (k_reg == 3'd6) begin
                    wr.tgt_we = 1'b1;
                    wr.waddr  = cur_addr;
                    wr.tgt    = blend_r;
                    x_next    = x_adv;
                    y_next    = y_adv;
                    z_next    = z_adv;
                    if (last_cell) begin
                        fa_next    = 2'd0;
                        fu_next    = CW'(1);
                        fv_next    = CW'(1);
                        side_next  = 1'b0;
                        state_next = S_F_RD;
                    end else begin
                        state_next = S_C_RD;
                    end
                end else begin
                    k_next     = k_reg + 3'd1;
                    state_next = S_B_M1;
                end
            end
            // face rules: inner layer to padding, normal component negated (x: low face only)
            S_F_RD: begin
                raddr      = f_rd_addr;
                state_next = S_F_WR;
            end
            S_F_WR: begin
                wr.tgt_we  = 1'b1;
                wr.waddr   = f_wr_addr;
                wr.tgt     = f_neg ? sla_pkg::neg_sat(rd.tgt) : rd.tgt;
                side_next  = !side_reg;
                state_next = S_F_RD;
                if (side_reg) begin
                    if (fv_reg != fvmax) begin
                        fv_next = fv_reg + CW'(1);
                    end else begin
                        fv_next = CW'(1);
                        if (fu_reg != fumax) begin
                            fu_next = fu_reg + CW'(1);
                        end else begin
                            fu_next = CW'(1);
                            fa_next = fa_reg + 2'd1;
                            if (fa_reg == 2'd2) begin
                                x_next = CW'(1);
                                y_next = CW'(1);
                                z_next = CW'(1);
                                k_next = NB_SELF;
                                if (comp_reg == sla_pkg::COMP_SCALAR)
                                    state_next = S_DONE;
                                else
                                    state_next = S_N_RD;
                            end
                        end
                    end
                end
            end
            // no-slip: fluid cells next to an interior solid become zero
            S_N_RD: begin
                raddr      = nb_addr;
                state_next = S_N_CHK;
            end
            S_N_CHK: begin
                if ((k_reg == NB_SELF && rd.sol) || (k_reg != NB_SELF && nb_ok && rd.sol)
                    || k_reg == NB_ZM) begin
                    if (k_reg != NB_SELF && nb_ok && rd.sol) begin
                        wr.tgt_we = 1'b1;
                        wr.waddr  = cur_addr;
                        wr.tgt    = '0;
                    end
                    x_next = x_adv;
                    y_next = y_adv;
                    z_next = z_adv;
                    k_next = NB_SELF;
                    if (last_cell)
                        state_next = S_DONE;
                    else
                        state_next = S_N_RD;
                end else begin
                    k_next     = k_reg + 3'd1;
                    state_next = S_N_RD;
                end
            end
            S_DONE: begin
                res_push   = 1'b1;
                res_done   = 1'b1;
                state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // result buffer: the second entry moves up when the first one leaves
        if (m_valid_reg && m_tready) begin
            m_valid_next  = sk_valid_reg;
            m_data_next   = sk_data_reg;
            m_done_next   = sk_done_reg;
            sk_valid_next = 1'b0;
        end
        if (res_push) begin
            if (!m_valid_next) begin
                m_valid_next = 1'b1;
                m_data_next  = res_data;
                m_done_next  = res_done;
            end else begin
                sk_valid_next = 1'b1;
                sk_data_next  = res_data;
                sk_done_next  = res_done;
            end
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLR;
            clr_reg      <= '0;
            m_valid_reg  <= 1'b0;
            sk_valid_reg <= 1'b0;
            size_x_reg   <= CW'(sla_pkg::MAX_DIM);
            size_y_reg   <= CW'(sla_pkg::MAX_DIM);
            size_z_reg   <= CW'(sla_pkg::MAX_DIM);
            dt_reg       <= 16'd655;
            comp_reg     <= sla_pkg::COMP_SCALAR;
        end else begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            m_valid_reg  <= m_valid_next;
            sk_valid_reg <= sk_valid_next;
            if (cfg_valid) begin
                case (cfg_addr)
                    sla_pkg::REG_SIZE_X:    size_x_reg <= cfg_data[CW-1:0];
                    sla_pkg::REG_SIZE_Y:    size_y_reg <= cfg_data[CW-1:0];
                    sla_pkg::REG_SIZE_Z:    size_z_reg <= cfg_data[CW-1:0];
                    sla_pkg::REG_TIME_STEP: dt_reg     <= cfg_data;
                    sla_pkg::REG_COMPONENT: comp_reg   <= cfg_data[1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        m_data_reg  <= m_data_next;
        m_done_reg  <= m_done_next;
        sk_data_reg <= sk_data_next;
        sk_done_reg <= sk_done_next;
        rd_in_reg   <= rd_in_next;
        ax_reg      <= ax_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        z_reg       <= z_next;
        k_reg       <= k_next;
        dtn_reg     <= dtn_next;
        vel_reg     <= vel_next;
        pos_reg     <= pos_next;
        frac_reg    <= frac_next;
        q_reg       <= q_next;
        acc_reg     <= acc_next;
        fa_reg      <= fa_next;
        fu_reg      <= fu_next;
        fv_reg      <= fv_next;
        side_reg    <= side_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_done_reg;

endmodule
